// ----- rtl/rcc_pkg.sv -----
// Shared types, constants and helpers for the repetition code codec.
`timescale 1ns / 1ps
package rcc_pkg;

  localparam int unsigned MaxRepetition = 64;
  localparam int unsigned RepW          = 7;
  localparam int unsigned RepCntW       = $clog2(MaxRepetition);
  localparam int unsigned ByteW         = 8;
  localparam int unsigned BitIdxW       = 3;
  localparam int unsigned BitCntW       = 3;
  localparam int unsigned CfgIdxW       = 8;

  localparam logic [CfgIdxW-1:0] CfgMode       = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRepetition = CfgIdxW'(1);

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRun,
    StFinal,
    StFlush,
    StEnd
  } rcc_state_e;

  // Clamp a written repetition to 1..MaxRepetition.
  function automatic logic [RepW-1:0] rcc_eff_rep(input logic [RepW-1:0] r);
    logic [RepW-1:0] res;
    res = r;
    if (r == '0) begin
      res = RepW'(1);
    end else if (r > RepW'(MaxRepetition)) begin
      res = RepW'(MaxRepetition);
    end
    return res;
  endfunction

endpackage

// ----- rtl/repetition_code_codec.sv -----
// Repetition code codec top level: bit-serial encoder and majority-vote decoder.
// Operation: an input byte is worked one code bit per cycle unless the output stalls,
// then closed through StFinal (decode, last byte), StFlush (last byte) and StEnd.
// A new byte is taken only in StIdle, after the last one is closed; every produced bit
// goes through the single bit-push unit that packs it into the output byte.
// Reset: mode clears to encode, repetition to 3; state, counters and valid flags clear.
`timescale 1ns / 1ps
module repetition_code_codec
  import rcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RepW-1:0]    cfg_data_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic               s_axis_tlast,   // in_last
  // output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,   // [7:0] out_byte
  output logic               m_axis_tuser,   // [0] has_data
  output logic               m_axis_tlast    // out_last
);

  rcc_state_e state_q, state_d;

  logic                mode_q, mode_d;
  logic [RepW-1:0]     rep_q, rep_d;

  logic [ByteW-1:0]    in_byte_q, in_byte_d;
  logic                in_last_q, in_last_d;
  logic [BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [RepCntW-1:0]  rep_cnt_q, rep_cnt_d;

  logic [ByteW-1:0]    shift_q, shift_d;
  logic [BitCntW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [RepW-1:0]     fill_q, fill_d;
  logic [RepW-1:0]     zeros_q, zeros_d;

  logic                hold_vld_q, hold_vld_d;
  logic [ByteW-1:0]    hold_q, hold_d;

  logic                out_vld_q, out_vld_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic                out_has_q, out_has_d;
  logic                out_last_q, out_last_d;

  logic                out_free;
  logic                cur_bit;
  logic [RepW-1:0]     thr;
  logic [RepW-1:0]     fill_inc;
  logic [RepW-1:0]     zeros_inc;
  logic [RepCntW-1:0]  rep_m1;
  logic                push_en;
  logic                push_b;
  logic                prod;
  logic [ByteW-1:0]    prod_byte;
  logic                go;
  logic                bit_done;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign cur_bit   = in_byte_q[bit_idx_q];
  assign thr       = RepW'(({1'b0, rep_q} + 8'd1) >> 1);
  assign fill_inc  = fill_q + RepW'(1);
  assign zeros_inc = zeros_q + RepW'(!cur_bit);
  assign rep_m1    = RepCntW'(rep_q - RepW'(1));

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    rep_d      = rep_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    bit_idx_d  = bit_idx_q;
    rep_cnt_d  = rep_cnt_q;
    shift_d    = shift_q;
    bit_cnt_d  = bit_cnt_q;
    fill_d     = fill_q;
    zeros_d    = zeros_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_byte_d = out_byte_q;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;

    push_en   = 1'b0;
    push_b    = 1'b0;
    bit_done  = 1'b0;
    prod      = 1'b0;
    prod_byte = {shift_q[ByteW-2:0], 1'b0};

    // select the bit source for this step
    case (state_q)
      StRun: begin
        if (mode_q == ModeEncode) begin
          push_en  = 1'b1;
          push_b   = cur_bit;
          bit_done = (rep_cnt_q == rep_m1);
        end else begin
          push_en  = (fill_inc >= rep_q);
          push_b   = !(zeros_inc >= thr);
          bit_done = 1'b1;
        end
      end
      StFinal: begin
        push_en = (fill_q != '0);
        push_b  = !(zeros_q >= thr);
      end
      default: begin
        push_en = 1'b0;
      end
    endcase

    if (state_q == StFlush) begin
      prod      = (bit_cnt_q != '0);
      prod_byte = shift_q;
    end else begin
      prod      = push_en && (bit_cnt_q == BitCntW'(ByteW - 1));
      prod_byte = {shift_q[ByteW-2:0], push_b};
    end

    go = !prod || !hold_vld_q || out_free;

    // shared push and hold path
    if (go && (state_q == StRun || state_q == StFinal || state_q == StFlush)) begin
      if (state_q == StFlush) begin
        shift_d   = '0;
        bit_cnt_d = '0;
      end else if (push_en) begin
        if (prod) begin
          shift_d   = '0;
          bit_cnt_d = '0;
        end else begin
          shift_d   = prod_byte;
          bit_cnt_d = bit_cnt_q + BitCntW'(1);
        end
      end
      if (prod) begin
        if (hold_vld_q) begin
          out_vld_d  = 1'b1;
          out_byte_d = hold_q;
          out_has_d  = 1'b1;
          out_last_d = 1'b0;
        end
        hold_vld_d = 1'b1;
        hold_d     = prod_byte;
      end
    end

    case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          if (cfg_index_i == CfgMode) begin
            mode_d = cfg_data_i[0];
          end else if (cfg_index_i == CfgRepetition) begin
            rep_d = rcc_eff_rep(cfg_data_i);
          end
          if (cfg_index_i == CfgMode || cfg_index_i == CfgRepetition) begin
            shift_d   = '0;
            bit_cnt_d = '0;
            fill_d    = '0;
            zeros_d   = '0;
          end
        end else if (s_axis_tvalid) begin
          in_byte_d = s_axis_tdata;
          in_last_d = s_axis_tlast;
          bit_idx_d = BitIdxW'(ByteW - 1);
          rep_cnt_d = '0;
          state_d   = StRun;
        end
      end
      StRun: begin
        if (go) begin
          if (mode_q == ModeDecode) begin
            if (push_en) begin
              fill_d  = '0;
              zeros_d = '0;
            end else begin
              fill_d  = fill_inc;
              zeros_d = zeros_inc;
            end
          end
          if (bit_done) begin
            rep_cnt_d = '0;
            bit_idx_d = bit_idx_q - BitIdxW'(1);
            if (bit_idx_q == '0) begin
              if (in_last_q && mode_q == ModeDecode) begin
                state_d = StFinal;
              end else if (in_last_q) begin
                state_d = StFlush;
              end else begin
                state_d = StEnd;
              end
            end
          end else begin
            rep_cnt_d = rep_cnt_q + RepCntW'(1);
          end
        end
      end
      StFinal: begin
        if (go) begin
          fill_d  = '0;
          zeros_d = '0;
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (go) begin
          state_d = StEnd;
        end
      end
      StEnd: begin
        if (hold_vld_q) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_byte_d = hold_q;
            out_has_d  = 1'b1;
            out_last_d = in_last_q;
            hold_vld_d = 1'b0;
            state_d    = StIdle;
          end
        end else if (in_last_q) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_byte_d = '0;
            out_has_d  = 1'b0;
            out_last_d = 1'b1;
            state_d    = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mode_q     <= ModeEncode;
      rep_q      <= RepW'(3);
      shift_q    <= '0;
      bit_cnt_q  <= '0;
      fill_q     <= '0;
      zeros_q    <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      bit_idx_q  <= '0;
      rep_cnt_q  <= '0;
      in_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      rep_q      <= rep_d;
      shift_q    <= shift_d;
      bit_cnt_q  <= bit_cnt_d;
      fill_q     <= fill_d;
      zeros_q    <= zeros_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      bit_idx_q  <= bit_idx_d;
      rep_cnt_q  <= rep_cnt_d;
      in_last_q  <= in_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q  <= in_byte_d;
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;

endmodule
